// File: rtl/core/chol_pkg.sv
// Shared constants and the command beat passed from the front end to the sequencer.
package chol_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SIZE_W        = 4;
  localparam int IDX_W         = 3;
  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;
  localparam int FIFO_DEPTH    = 2;

  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     start;
  } chol_cmd_t;

endpackage

// File: rtl/core/chol_if.sv
// Valid/ready channel interfaces for matrix element input and factor output.
interface chol_in_if;
  import chol_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;
  logic                     load_done;

  modport source (output valid, row_index, col_index, element_value, load_done,
                  input ready);
  modport sink (input valid, row_index, col_index, element_value, load_done,
                output ready);
endinterface

interface chol_out_if;
  import chol_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] factor_value;
  logic                     not_positive_definite;
  logic                     last_result;

  modport source (output valid, out_row, out_col, factor_value, not_positive_definite,
                  last_result, input ready);
  modport sink (input valid, out_row, out_col, factor_value, not_positive_definite,
                last_result, output ready);
endinterface

// File: rtl/core/cholesky_factorization.sv
// Top level: size register, front end, command queue and factorization sequencer.
//
//   channel   dir  handshake      beat
//   in_chan   in   valid/ready    row_index, col_index, element_value, load_done
//   out_chan  out  valid/ready    out_row, out_col, factor_value, not_positive_definite,
//                                 last_result
//   cfg       in   cfg_we_i       cfg_wdata_i -> size_in_use
//
// Load beats are queued by the front end and stored by the sequencer. Per factor entry:
// a read, multiply and accumulate state per product term, then remainder and write-back
// states, plus the bit-serial root (diagonal) or divider (below it); the divider sets
// the pace. Read-out has a read and a put state per beat. Input stalls only when the
// queue fills; output stalls hold the sequencer. Reset clears control state only.
module cholesky_factorization #(
  parameter int MAX_DIM   = chol_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chol_pkg::SIZE_W-1:0] cfg_wdata_i,
  chol_in_if.sink                     in_chan,
  chol_out_if.source                  out_chan
);
  import chol_pkg::*;

  logic [SIZE_W-1:0] size_q;
  chol_cmd_t         push_cmd, pop_cmd;
  logic              push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  chol_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_chan (in_chan),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  chol_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  chol_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .size_i   (size_q),
    .cmd_i    (pop_cmd),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule

// File: rtl/core/chol_ram.sv
// Generic RAM: one write port, two registered read ports.
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/core/chol_fifo.sv
// Short command queue between the front end and the sequencer.
module chol_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  chol_pkg::chol_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output chol_pkg::chol_cmd_t cmd_o,
  output logic                empty_o
);
  import chol_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  chol_cmd_t        buf_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = buf_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/chol_front.sv
// Input front end: mirrors upper-triangle elements, range-checks and queues each beat.
module chol_front #(
  parameter int MAX_DIM = chol_pkg::MAX_DIM_DEF
) (
  chol_in_if.sink             in_chan,
  input  logic                full_i,
  output logic                push_o,
  output chol_pkg::chol_cmd_t cmd_o
);
  import chol_pkg::*;

  logic             swap;
  logic [IDX_W-1:0] row, col;

  assign swap = in_chan.col_index > in_chan.row_index;
  assign row  = swap ? in_chan.col_index : in_chan.row_index;
  assign col  = swap ? in_chan.row_index : in_chan.col_index;

  assign in_chan.ready = !full_i;
  assign push_o        = in_chan.valid && !full_i;

  always_comb begin
    cmd_o.wr_en = (int'(row) < MAX_DIM);
    cmd_o.row   = row;
    cmd_o.col   = col;
    cmd_o.value = in_chan.element_value;
    cmd_o.start = in_chan.load_done;
  end

endmodule

// File: rtl/core/chol_back.sv
// Sequencer: store writes, dot products, bit-serial root and divide, factor read-out.
module chol_back #(
  parameter int MAX_DIM   = chol_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [chol_pkg::SIZE_W-1:0] size_i,
  input  chol_pkg::chol_cmd_t         cmd_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  chol_out_if.source                  out_chan
);
  import chol_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int IT_W   = 7;
  localparam logic [IT_W-1:0] SQRT_LAST = IT_W'(31);
  localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(63);
  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_REM_RD, S_REM, S_CHK,
    S_SQRT, S_DIV, S_FIN, S_WB, S_ERR, S_EM_RD, S_EM_PUT
  } state_e;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
    addr_of = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_fix(input logic [ACC_W:0] s);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_fix = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_fix = s[ACC_W-1:0];
    end
  endfunction

  state_e                   state_q;
  logic [CNT_W-1:0]         i_q, j_q, k_q, n_q;
  logic signed [ACC_W-1:0]  sum_q, prod_q, rem_q;
  logic [ACC_W-1:0]         acc_q, res_q, bit_q;
  logic [DATA_W-1:0]        dr_q, d_q;
  logic                     neg_q;
  logic signed [DATA_W-1:0] wval_q;
  logic [IT_W-1:0]          it_q;

  logic                     out_vld_q, out_npd_q, out_last_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [DATA_W-1:0] out_val_q;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0]        ram_wdata, rdata_a, rdata_b;

  logic                     out_free;
  logic                     out_set;
  logic [ACC_W-1:0]         sq_t;
  logic                     sq_ge;
  logic [DATA_W:0]          dv_t;
  logic                     dv_ge;
  logic signed [ACC_W-1:0]  a_sh, sum_nx, rem_nx;
  logic [CNT_W-1:0]         i_nx, j_nx, k_nx, size_n;

  assign out_free = !out_vld_q || out_chan.ready;
  // a new beat is loaded into the output register this cycle
  assign out_set  = out_free && (state_q == S_ERR || state_q == S_EM_PUT);
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  assign sq_t  = res_q + bit_q;
  assign sq_ge = acc_q >= sq_t;
  assign dv_t  = {dr_q, acc_q[ACC_W-1]};
  assign dv_ge = dv_t >= {1'b0, d_q};

  assign a_sh   = ACC_W'($signed(rdata_a)) <<< FRAC_BITS;
  assign sum_nx = sat_fix({sum_q[ACC_W-1], sum_q} + {prod_q[ACC_W-1], prod_q});
  assign rem_nx = sat_fix({a_sh[ACC_W-1], a_sh} - {sum_q[ACC_W-1], sum_q});
  assign i_nx   = i_q + CNT_W'(1);
  assign j_nx   = j_q + CNT_W'(1);
  assign k_nx   = k_q + CNT_W'(1);

  always_comb begin
    if (size_i == '0) begin
      size_n = CNT_W'(1);
    end else if (int'(size_i) > MAX_DIM) begin
      size_n = CNT_W'(MAX_DIM);
    end else begin
      size_n = CNT_W'(size_i);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(j_q, i_q);
    ram_wdata = wval_q;
    if (pop_o && cmd_i.wr_en) begin
      ram_we    = 1'b1;
      ram_waddr = addr_of(CNT_W'(cmd_i.row), CNT_W'(cmd_i.col));
      ram_wdata = cmd_i.value;
    end else if (state_q == S_WB) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    raddr_b = addr_of(i_q, k_q);
    case (state_q)
      S_MAC_RD, S_MAC_MUL: raddr_a = addr_of(j_q, k_q);
      S_REM_RD, S_REM:     raddr_a = addr_of(j_q, i_q);
      default:             raddr_a = addr_of(i_q, j_q);
    endcase
  end

  chol_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      n_q       <= '0;
      it_q      <= '0;
    end else begin
      if (out_vld_q && out_chan.ready && !out_set) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o && cmd_i.start) begin
            n_q     <= size_n;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_ROW;
          end
        end
        S_ROW: begin
          sum_q   <= '0;
          k_q     <= '0;
          state_q <= (i_q != '0) ? S_MAC_RD : S_REM_RD;
        end
        S_MAC_RD: state_q <= S_MAC_MUL;
        S_MAC_MUL: begin
          prod_q  <= $signed(rdata_a) * $signed(rdata_b);
          state_q <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          sum_q   <= sum_nx;
          k_q     <= k_nx;
          state_q <= (k_nx == i_q) ? S_REM_RD : S_MAC_RD;
        end
        S_REM_RD: state_q <= S_REM;
        S_REM: begin
          rem_q   <= rem_nx;
          state_q <= S_CHK;
        end
        S_CHK: begin
          it_q  <= '0;
          res_q <= '0;
          if (j_q == i_q) begin
            acc_q   <= rem_q;
            bit_q   <= {2'b01, {(ACC_W-2){1'b0}}};
            state_q <= (rem_q <= 0) ? S_ERR : S_SQRT;
          end else begin
            // divide on the magnitude; sign applied at the end
            neg_q   <= rem_q[ACC_W-1];
            acc_q   <= rem_q[ACC_W-1] ? -rem_q : rem_q;
            dr_q    <= '0;
            state_q <= S_DIV;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            acc_q <= acc_q - sq_t;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          it_q  <= it_q + IT_W'(1);
          if (it_q == SQRT_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          dr_q  <= dv_ge ? DATA_W'(dv_t - {1'b0, d_q}) : dv_t[DATA_W-1:0];
          res_q <= {res_q[ACC_W-2:0], dv_ge};
          acc_q <= acc_q << 1;
          it_q  <= it_q + IT_W'(1);
          if (it_q == DIV_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (j_q == i_q || !neg_q) begin
            wval_q <= (res_q > ACC_W'(S32_MAX)) ? S32_MAX : res_q[DATA_W-1:0];
          end else begin
            wval_q <= (res_q >= {{(ACC_W-DATA_W){1'b0}}, S32_MIN}) ? S32_MIN
                                                                  : -res_q[DATA_W-1:0];
          end
          state_q <= S_WB;
        end
        S_WB: begin
          if (j_q == i_q) begin
            d_q <= wval_q;
          end
          if (j_nx < n_q) begin
            j_q     <= j_nx;
            state_q <= S_ROW;
          end else if (i_nx < n_q) begin
            i_q     <= i_nx;
            j_q     <= i_nx;
            state_q <= S_ROW;
          end else begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_EM_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_row_q  <= IDX_W'(i_q);
            out_col_q  <= IDX_W'(i_q);
            out_val_q  <= '0;
            out_npd_q  <= 1'b1;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        S_EM_RD: state_q <= S_EM_PUT;
        S_EM_PUT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_row_q  <= IDX_W'(i_q);
            out_col_q  <= IDX_W'(j_q);
            out_val_q  <= rdata_a;
            out_npd_q  <= 1'b0;
            out_last_q <= (i_nx == n_q) && (j_q == i_q);
            if (j_q != i_q) begin
              j_q     <= j_nx;
              state_q <= S_EM_RD;
            end else if (i_nx != n_q) begin
              i_q     <= i_nx;
              j_q     <= '0;
              state_q <= S_EM_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid                 = out_vld_q;
  assign out_chan.out_row               = out_row_q;
  assign out_chan.out_col               = out_col_q;
  assign out_chan.factor_value          = out_val_q;
  assign out_chan.not_positive_definite = out_npd_q;
  assign out_chan.last_result           = out_last_q;

endmodule

// File: tb/chol_checker.sv
// Watches both channels and the size port, predicts the factor beats and compares them.
`timescale 1ns / 1ps

module chol_checker import chol_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  chol_in_if                in_mon,
  chol_out_if               out_mon,
  output int                fail_count_o,
  output int                pending_o,
  output int                beats_seen_o,
  output int                error_beats_o
);

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     npd;
    logic                     last;
  } factor_beat_t;

  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  logic signed [DATA_W-1:0] mat_q [MAX_DIM_DEF][MAX_DIM_DEF];
  logic [SIZE_W-1:0]        size_q;
  factor_beat_t             factor_q [$];

  function automatic longint clamp64(logic signed [ACC_W:0] s);
    if (s > I64_MAX) return I64_MAX;
    if (s < I64_MIN) return I64_MIN;
    return longint'(s);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // A[r][c] scaled up, less the dot product over the columns left of c
  function automatic longint residue(int r, int c);
    logic signed [ACC_W:0] s;
    longint acc;
    acc = 0;
    for (int k = 0; k < c; k++) begin
      s = acc;
      s = s + longint'(mat_q[r][k]) * longint'(mat_q[c][k]);
      acc = clamp64(s);
    end
    s = longint'(mat_q[r][c]) <<< FRAC_BITS_DEF;
    s = s - acc;
    return clamp64(s);
  endfunction

  task automatic factorize();
    int n;
    longint rem;
    logic signed [DATA_W-1:0] d;
    factor_beat_t fb;
    n = (size_q == 0) ? 1 : (size_q > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_q);
    for (int i = 0; i < n; i++) begin
      rem = residue(i, i);
      if (rem <= 0) begin
        fb = '{row: IDX_W'(i), col: IDX_W'(i), value: '0, npd: 1'b1, last: 1'b1};
        factor_q.push_back(fb);
        return;
      end
      d = clamp32(longint'(root64(rem)));
      mat_q[i][i] = d;
      for (int j = i + 1; j < n; j++) mat_q[j][i] = clamp32(residue(j, i) / longint'(d));
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        fb = '{row: IDX_W'(i), col: IDX_W'(j), value: mat_q[i][j], npd: 1'b0,
               last: (i == n - 1 && j == i)};
        factor_q.push_back(fb);
      end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    factor_beat_t got, want;
    logic [IDX_W-1:0] r, c;
    if (!rst_ni) begin
      size_q = SIZE_W'(MAX_DIM_DEF);
      factor_q.delete();
      fail_count_o = 0;
      beats_seen_o = 0;
      error_beats_o = 0;
    end else begin
      if (cfg_we_i) size_q = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        r = in_mon.row_index;
        c = in_mon.col_index;
        if (c > r) mat_q[c][r] = in_mon.element_value;
        else mat_q[r][c] = in_mon.element_value;
        if (in_mon.load_done) factorize();
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{row: out_mon.out_row, col: out_mon.out_col, value: out_mon.factor_value,
                npd: out_mon.not_positive_definite, last: out_mon.last_result};
        beats_seen_o++;
        if (got.npd) error_beats_o++;
        if (factor_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t unexpected beat: row %0d col %0d value %0d npd %0b last %0b",
                     $realtime, got.row, got.col, got.value, got.npd, got.last);
        end else begin
          want = factor_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t mismatch: exp row %0d col %0d value %0d npd %0b last %0b; got row %0d col %0d value %0d npd %0b last %0b",
                       $realtime, want.row, want.col, want.value, want.npd, want.last,
                       got.row, got.col, got.value, got.npd, got.last);
          end
        end
      end
    end
    pending_o = factor_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the fixed-point Cholesky factorization block.
`timescale 1ns / 1ps

module tb_top;
  import chol_pkg::*;

  typedef enum int {MAT_SPD, MAT_RANDOM, MAT_BAD_DIAG, MAT_TINY_DIAG, MAT_EXTREME,
                    MAT_PARTIAL} mat_kind_e;

  localparam int WATCHDOG_LIMIT = 40000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                idle_in, idle_out;
  int                fail_count, pending, beats_seen, error_beats;
  int                items_sent, matrices_done, stall_cycles;
  int                bad_idx;
  logic              written [MAX_DIM_DEF][MAX_DIM_DEF];

  chol_in_if  in_chan ();
  chol_out_if out_chan ();

  cholesky_factorization DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  chol_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .beats_seen_o  (beats_seen),
    .error_beats_o (error_beats)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= ($urandom_range(99) >= idle_out);
  end

  // cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles = 0;
    else if (++stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, pending);
      $display("[cholesky_factorization] ERROR");
      $finish;
    end
  end

  task automatic send_elem(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic signed [DATA_W-1:0] v, logic ld);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_in) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.row_index     <= r;
    in_chan.col_index     <= c;
    in_chan.element_value <= v;
    in_chan.load_done     <= ld;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (c > r) written[c][r] = 1'b1;
    else written[r][c] = 1'b1;
  endtask

  // hold the sender until every factor beat is back, then let queued loads settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(mat_kind_e kind, int r, int c,
                                                           int n);
    case (kind)
      MAT_SPD, MAT_PARTIAL, MAT_BAD_DIAG: begin
        if (r != c) return $signed($urandom_range(131070)) - 65535;
        if (kind == MAT_BAD_DIAG && r == bad_idx) return -$signed($urandom_range(1 << 20));
        return n * 65536 + 65536 + $urandom_range(1 << 20);
      end
      MAT_TINY_DIAG: return (r == c) ? $signed($urandom_range(1, 4)) : $signed($urandom);
      MAT_EXTREME: begin
        if (r == c) return 32'sh7FFF_FFFF;
        return ((r + c) % 2 != 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic load_matrix(int n, mat_kind_e kind);
    int  cells [MAX_DIM_DEF * MAX_DIM_DEF];
    int  cnt, sends, k, t, r, c;
    logic all_there;
    cnt = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) cells[cnt++] = i * MAX_DIM_DEF + j;
    for (int i = cnt - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = cells[i];
      cells[i] = cells[k];
      cells[k] = t;
    end
    bad_idx = $urandom_range(n - 1);
    all_there = 1'b1;
    for (int i = 0; i < cnt; i++)
      if (!written[cells[i] / MAX_DIM_DEF][cells[i] % MAX_DIM_DEF]) all_there = 1'b0;
    // a partial reload may only go out when every entry it reads already holds data
    if (kind == MAT_PARTIAL && !all_there) kind = MAT_SPD;
    sends = (kind == MAT_PARTIAL) ? $urandom_range(1, cnt) : cnt;
    // rows beyond the size in use are stored but never read
    if (n < MAX_DIM_DEF && $urandom_range(3) == 0)
      send_elem(IDX_W'($urandom_range(n, MAX_DIM_DEF - 1)), IDX_W'($urandom_range(7)),
                $signed($urandom), 1'b0);
    for (int i = 0; i < sends; i++) begin
      r = cells[i] / MAX_DIM_DEF;
      c = cells[i] % MAX_DIM_DEF;
      if (r != c && $urandom_range(1)) begin
        t = r;
        r = c;
        c = t;
      end
      send_elem(IDX_W'(r), IDX_W'(c), pick_value(kind, cells[i] / MAX_DIM_DEF,
                cells[i] % MAX_DIM_DEF, n), i == sends - 1);
    end
    matrices_done++;
  endtask

  initial begin
    int n, raw;
    mat_kind_e kind;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_in = 22;
    idle_out = 53;
    items_sent = 0;
    matrices_done = 0;
    stall_cycles = 0;
    in_chan.valid = 1'b0;
    in_chan.row_index = '0;
    in_chan.col_index = '0;
    in_chan.element_value = '0;
    in_chan.load_done = 1'b0;
    for (int i = 0; i < MAX_DIM_DEF; i++)
      for (int j = 0; j < MAX_DIM_DEF; j++) written[i][j] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: size extremes, clamped sizes, saturation and failing diagonals
    write_size(4'd1);
    load_matrix(1, MAT_EXTREME);
    write_size(4'd0);
    load_matrix(1, MAT_BAD_DIAG);
    write_size(4'd2);
    load_matrix(2, MAT_TINY_DIAG);
    load_matrix(2, MAT_EXTREME);
    write_size(4'd3);
    load_matrix(3, MAT_SPD);
    load_matrix(3, MAT_PARTIAL);
    load_matrix(3, MAT_BAD_DIAG);

    while (items_sent < 255) begin
      if (items_sent > 190) begin
        idle_in = 0;
        idle_out = 0;
      end else if (items_sent > 100) begin
        idle_in = 53;
        idle_out = 22;
      end
      if ($urandom_range(1) || matrices_done < 10) begin
        raw = $urandom_range(9);
        raw = (raw == 0) ? 0 : (raw == 9) ? $urandom_range(9, 15) : ($urandom_range(1) ?
              $urandom_range(1, 4) : $urandom_range(5, 8));
        write_size(SIZE_W'(raw));
        n = (raw == 0) ? 1 : (raw > MAX_DIM_DEF) ? MAX_DIM_DEF : raw;
      end
      case ($urandom_range(9))
        0, 1, 2, 3: kind = MAT_SPD;
        4:          kind = MAT_RANDOM;
        5, 6:       kind = MAT_PARTIAL;
        7:          kind = MAT_BAD_DIAG;
        8:          kind = MAT_TINY_DIAG;
        default:    kind = MAT_EXTREME;
      endcase
      load_matrix(n, kind);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d element beats over %0d matrices of sizes 1 to %0d", items_sent,
             matrices_done, MAX_DIM_DEF);
    $display("checked %0d factor beats, %0d of them not-positive-definite reports",
             beats_seen, error_beats);
    if (fail_count == 0 && pending == 0)
      $display("[cholesky_factorization] OK");
    else
      $display("[cholesky_factorization] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/chol_pkg.sv
rtl/core/chol_if.sv
rtl/core/chol_ram.sv
rtl/core/chol_fifo.sv
rtl/core/chol_front.sv
rtl/core/chol_back.sv
rtl/core/cholesky_factorization.sv
tb/chol_checker.sv
tb/tb_top.sv
